// ----- design/eps_pkg.sv -----
// Shared types and constants for the encoder position and speed capture block.
`timescale 1ns / 1ps

package eps_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned OVF_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM      = 3'd3;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_CAPTURE = 1'b1;

  localparam logic [DATA_W-1:0] TIMER_PERIOD_RST   = 32'd65535;
  localparam logic [OVF_W-1:0]  OVERFLOW_LIMIT_RST = 16'd16;
  localparam logic [DATA_W-1:0] SPEED_NUM_RST      = 32'd100;

  localparam logic [DATA_W-1:0] SPEED_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SPEED_NEG_MAX = 32'h8000_0000;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ELAPSE = 6'b000010,
    ST_SIGN   = 6'b000100,
    ST_SETUP  = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

endpackage

// ----- design/encoder_position_speed_capture.sv -----
// Encoder position tracker with interval capture and serial speed divider.
// Steps: a tick or first capture goes to setup, the divide, then done; a later capture
// goes through elapse and sign first; no divide when stopped or the interval is zero.
// One transaction at a time; done holds while the output register is full and stalled;
// a finished result waits in the output register while the next transaction is taken.
// Reset (synchronous, active low): registers to defaults, position zero, stopped and re-arm set.
`timescale 1ns / 1ps

module encoder_position_speed_capture (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic [eps_pkg::DATA_W-1:0]           in_capture_value,
  input  logic                                 in_level_a,
  input  logic                                 in_level_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [eps_pkg::DATA_W-1:0]           out_position,
  output logic signed [eps_pkg::DATA_W-1:0]    out_speed,
  output logic                                 out_is_stopped,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [eps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [eps_pkg::DATA_W-1:0]           cfg_wdata
);

  eps_pkg::state_t state_r;

  logic [eps_pkg::DATA_W-1:0]    timer_period_r;
  logic [eps_pkg::OVF_W-1:0]     overflow_limit_r;
  logic                          reverse_r;
  logic [eps_pkg::DATA_W-1:0]    speed_numerator_r;

  logic [eps_pkg::DATA_W-1:0]    abs_position_r;
  logic [eps_pkg::DATA_W-1:0]    previous_capture_r;
  logic [eps_pkg::OVF_W-1:0]     ovf_count_r;
  logic                          stopped_r;
  logic                          awaiting_r;
  logic [eps_pkg::DATA_W-1:0]    interval_r;

  logic [eps_pkg::DATA_W-1:0]    prod_r;
  logic [eps_pkg::DATA_W-1:0]    cap_r;
  logic [eps_pkg::DATA_W-1:0]    elapsed_r;
  logic                          up_r;
  logic [eps_pkg::DATA_W-1:0]    mag_r;
  logic                          neg_r;
  logic [eps_pkg::DATA_W-1:0]    quot_r;
  logic [eps_pkg::DATA_W-1:0]    rem_r;
  logic [eps_pkg::DIV_CNT_W-1:0] cnt_r;

  logic                          out_valid_r;
  logic [eps_pkg::DATA_W-1:0]    out_position_r;
  logic [eps_pkg::DATA_W-1:0]    out_speed_r;
  logic                          out_is_stopped_r;

  logic                              in_accept;
  logic                              step_up;
  logic [eps_pkg::OVF_W:0]           ovf_inc;
  logic [eps_pkg::DATA_W+eps_pkg::OVF_W-1:0] prod_full;
  logic [eps_pkg::DATA_W:0]          rem_shift;
  logic [eps_pkg::DATA_W:0]          rem_diff;
  logic                              rem_ge;
  logic [eps_pkg::DATA_W-1:0]        quot_clamp;
  logic [eps_pkg::DATA_W-1:0]        speed_nxt;
  logic                              out_load;

  assign in_stall  = (state_r != eps_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign step_up   = (in_level_a != in_level_b) ^ reverse_r;
  assign ovf_inc   = {1'b0, ovf_count_r} + {{eps_pkg::OVF_W{1'b0}}, 1'b1};
  assign prod_full = {{eps_pkg::OVF_W{1'b0}}, timer_period_r}
                   * {{eps_pkg::DATA_W{1'b0}}, ovf_count_r};

  assign rem_shift = {rem_r, quot_r[eps_pkg::DATA_W-1]};
  assign rem_diff  = rem_shift - {1'b0, mag_r};
  assign rem_ge    = !rem_diff[eps_pkg::DATA_W];

  always_comb begin
    quot_clamp = (quot_r > eps_pkg::SPEED_NEG_MAX) ? eps_pkg::SPEED_NEG_MAX : quot_r;
    if (neg_r) begin
      speed_nxt = '0 - quot_clamp;
    end else begin
      speed_nxt = quot_r[eps_pkg::DATA_W-1] ? eps_pkg::SPEED_POS_MAX : quot_r;
    end
  end

  assign out_load = (state_r == eps_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_period_r    <= eps_pkg::TIMER_PERIOD_RST;
      overflow_limit_r  <= eps_pkg::OVERFLOW_LIMIT_RST;
      reverse_r         <= 1'b0;
      speed_numerator_r <= eps_pkg::SPEED_NUM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        eps_pkg::CFG_TIMER_PERIOD:   timer_period_r    <= cfg_wdata;
        eps_pkg::CFG_OVERFLOW_LIMIT: overflow_limit_r  <= cfg_wdata[eps_pkg::OVF_W-1:0];
        eps_pkg::CFG_REVERSE_DIR:    reverse_r         <= cfg_wdata[0];
        eps_pkg::CFG_SPEED_NUM:      speed_numerator_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= eps_pkg::ST_IDLE;
      abs_position_r     <= '0;
      previous_capture_r <= '0;
      ovf_count_r        <= '0;
      stopped_r          <= 1'b1;
      awaiting_r         <= 1'b1;
      interval_r         <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        eps_pkg::ST_IDLE: begin
          if (in_accept) begin
            if (in_action == eps_pkg::ACT_TICK) begin
              if (ovf_inc > {1'b0, overflow_limit_r}) begin
                ovf_count_r <= '0;
                stopped_r   <= 1'b1;
                awaiting_r  <= 1'b1;
              end else begin
                ovf_count_r <= ovf_inc[eps_pkg::OVF_W-1:0];
              end
              state_r <= eps_pkg::ST_SETUP;
            end else begin
              ovf_count_r    <= '0;
              abs_position_r <= step_up ? abs_position_r + 32'd1 : abs_position_r - 32'd1;
              up_r           <= step_up;
              cap_r          <= in_capture_value;
              prod_r         <= prod_full[eps_pkg::DATA_W-1:0];
              if (awaiting_r) begin
                awaiting_r         <= 1'b0;
                previous_capture_r <= in_capture_value;
                state_r            <= eps_pkg::ST_SETUP;
              end else begin
                stopped_r <= 1'b0;
                state_r   <= eps_pkg::ST_ELAPSE;
              end
            end
          end
        end
        eps_pkg::ST_ELAPSE: begin
          elapsed_r          <= prod_r + cap_r - previous_capture_r;
          previous_capture_r <= cap_r;
          state_r            <= eps_pkg::ST_SIGN;
        end
        eps_pkg::ST_SIGN: begin
          interval_r <= up_r ? elapsed_r : '0 - elapsed_r;
          state_r    <= eps_pkg::ST_SETUP;
        end
        eps_pkg::ST_SETUP: begin
          rem_r <= '0;
          cnt_r <= '0;
          if (stopped_r || (interval_r == '0)) begin
            quot_r  <= '0;
            neg_r   <= 1'b0;
            state_r <= eps_pkg::ST_DONE;
          end else begin
            quot_r  <= speed_numerator_r;
            neg_r   <= interval_r[eps_pkg::DATA_W-1];
            mag_r   <= interval_r[eps_pkg::DATA_W-1] ? '0 - interval_r : interval_r;
            state_r <= eps_pkg::ST_DIV;
          end
        end
        eps_pkg::ST_DIV: begin
          rem_r  <= rem_ge ? rem_diff[eps_pkg::DATA_W-1:0] : rem_shift[eps_pkg::DATA_W-1:0];
          quot_r <= {quot_r[eps_pkg::DATA_W-2:0], rem_ge};
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == {eps_pkg::DIV_CNT_W{1'b1}}) begin
            state_r <= eps_pkg::ST_DONE;
          end
        end
        eps_pkg::ST_DONE: begin
          if (out_load) begin
            state_r <= eps_pkg::ST_IDLE;
          end
        end
        default: state_r <= eps_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_position_r   <= abs_position_r;
      out_speed_r      <= speed_nxt;
      out_is_stopped_r <= stopped_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_position_r;
  assign out_speed      = out_speed_r;
  assign out_is_stopped = out_is_stopped_r;

endmodule

// ----- design/eps_checker.sv -----
// Port-level checker for the encoder position and speed capture block, with its bind.
`timescale 1ns / 1ps

module eps_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [eps_pkg::DATA_W-1:0]    out_speed,
  input logic                                 out_is_stopped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stopped_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_stopped |-> out_speed == '0)
    else $error("nonzero speed while stopped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction taken while busy");

endmodule

bind encoder_position_speed_capture eps_checker u_eps_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_speed      (out_speed),
  .out_is_stopped (out_is_stopped)
);
